// ===== rtl/lal_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lal_pkg: shared widths and constants for the LDR sample to lux converter
// Field widths, converter resolution and the register map used by all files.
// ----------------------------------------------------------------------------
package lal_pkg;

    // Converter resolution (8..16).
    localparam int ADC_BITS   = 12;
    localparam int RES_W      = 16;
    localparam int LUX_REF_W  = 10;
    localparam int LUX_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Q16 ratio and final scaling.
    localparam int FRAC_W = 16;
    localparam int RND_SH = 24;

    // Derived datapath widths.
    localparam int PROD_W = RES_W + ADC_BITS;      // resistance * sample
    localparam int NUM_W  = PROD_W + FRAC_W;       // dividend, and ratio
    localparam int ROOT_W = (NUM_W + 1) / 2;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int A_W    = LUX_REF_W + NUM_W;     // reference_lux * ratio
    localparam int P_W    = A_W + ROOT_W;          // full product

    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int SQRT_CNT_W = $clog2(ROOT_W);
    localparam int STEP_MAX   = (ROOT_W > ADC_BITS) ?
                                ((ROOT_W > LUX_REF_W) ? ROOT_W : LUX_REF_W) :
                                ((ADC_BITS > LUX_REF_W) ? ADC_BITS : LUX_REF_W);
    localparam int STEP_CNT_W = $clog2(STEP_MAX);

    localparam logic [ADC_BITS-1:0] ADC_FULL = '1;
    localparam logic [ADC_BITS-1:0] ADC_TOP  = {{(ADC_BITS-1){1'b1}}, 1'b0};

    // Register map.
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_RES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_RES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_LUX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BRIGHT = 2'd3;

    localparam logic [RES_W-1:0]     FIXED_RES_RST = 16'd10000;
    localparam logic [RES_W-1:0]     REF_RES_RST   = 16'd10000;
    localparam logic [LUX_REF_W-1:0] REF_LUX_RST   = 10'd10;

endpackage
`default_nettype wire

// ===== rtl/lal_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lal_div: radix-2 restoring divider
// Produces one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module lal_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [lal_pkg::NUM_W-1:0]  i_dividend,
    input  wire logic [lal_pkg::PROD_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [lal_pkg::NUM_W-1:0]       o_quotient
);
    import lal_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [PROD_W-1:0]    r_dvs;
    logic [PROD_W-1:0]    r_rem;
    logic [NUM_W-1:0]     r_quo;

    logic [PROD_W:0]      w_shift;
    logic [PROD_W:0]      w_diff;
    logic                 w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Shift the dividend out of the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[PROD_W-1:0] : w_shift[PROD_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== rtl/lal_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lal_sqrt: digit-by-digit integer square root
// Consumes two radicand bits and yields one root bit per cycle.
// ----------------------------------------------------------------------------
module lal_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [lal_pkg::SQ_W-1:0]  i_radicand,
    output logic                           o_done,
    output logic [lal_pkg::ROOT_W-1:0]     o_root
);
    import lal_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [SQRT_CNT_W-1:0] r_cnt, n_cnt;
    logic [SQ_W-1:0]       r_rad;
    logic [ROOT_W:0]       r_rem;
    logic [ROOT_W-1:0]     r_root;

    logic [ROOT_W+2:0]     w_shift;
    logic [ROOT_W+2:0]     w_trial;
    logic [ROOT_W+2:0]     w_diff;
    logic                  w_ge;

    always_comb begin
        w_shift = {r_rem, r_rad[SQ_W-1 -: 2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_diff  = w_shift - w_trial;
        w_ge    = (w_shift >= w_trial);
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SQRT_CNT_W'(ROOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // The remainder never exceeds twice the partial root, so it fits ROOT_W+1 bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[ROOT_W:0] : w_shift[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== rtl/photoresistor_adc_to_lux_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// photoresistor_adc_to_lux_unit: LDR divider ADC sample to illuminance
// One 12-bit sample in, one 32-bit lux value out, bit-serial datapath.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. An item passes, in order, through
// the two shift-add products (sensor and divider sides), the restoring
// divider that forms the Q16 ratio, the square-root unit (reference_lux *
// ratio is formed alongside it), the final shift-add product, and a
// handoff into the output register. The divider loop is the longest
// phase. o_in_ready is high whenever no sample is in progress; a finished
// result sits in the output register until taken, and a new sample may
// enter meanwhile. Configuration registers are written through a separate
// channel that is always ready; write them only while the unit is idle.
// ----------------------------------------------------------------------------
module photoresistor_adc_to_lux_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Sample channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [lal_pkg::ADC_BITS-1:0]   i_adc_sample,
    // Result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [lal_pkg::LUX_W-1:0]           o_lux,
    // Configuration channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lal_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lal_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lal_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_DIV  = 6'b000100,
        S_SQRT = 6'b001000,
        S_MUL2 = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // Control and configuration registers
    t_state                r_state, n_state;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic [RES_W-1:0]      r_fix, n_fix;
    logic [RES_W-1:0]      r_rref, n_rref;
    logic [LUX_REF_W-1:0]  r_rlux, n_rlux;
    logic                  r_hwb, n_hwb;
    logic                  r_div_start, n_div_start;
    logic                  r_sqrt_start, n_sqrt_start;
    logic                  r_a_run, n_a_run;
    logic                  r_out_valid, n_out_valid;

    // Datapath registers
    logic [ADC_BITS-1:0]   r_num, r_den;
    logic [RES_W-1:0]      r_pa_hi, r_pb_hi;
    logic [ADC_BITS-1:0]   r_pa_lo, r_pb_lo;
    logic [NUM_W-1:0]      r_ratio;
    logic [LUX_REF_W-1:0]  r_a_y;
    logic [NUM_W-1:0]      r_a_hi;
    logic [LUX_REF_W-1:0]  r_a_lo;
    logic [ROOT_W-1:0]     r_m2_y;
    logic [A_W-1:0]        r_m2_hi;
    logic [ROOT_W-1:0]     r_m2_lo;
    logic [LUX_W-1:0]      r_lux;

    // Combinational helpers
    logic                  w_in_xfer;
    logic                  w_out_load;
    logic [ADC_BITS-1:0]   w_sample;
    logic [ADC_BITS-1:0]   w_num, w_den;
    logic [RES_W-1:0]      w_fix_eff;
    logic [RES_W:0]        w_pa_sum, w_pb_sum;
    logic [NUM_W:0]        w_a_sum;
    logic [A_W:0]          w_m2_sum;
    logic [P_W-1:0]        w_prod;
    logic [LUX_W:0]        w_round;
    logic                  w_sat;
    logic [LUX_W-1:0]      w_lux;
    logic                  w_div_done, w_sqrt_done;
    logic [NUM_W-1:0]      w_quo;
    logic [ROOT_W-1:0]     w_root;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid & o_in_ready;
    assign w_out_load  = (r_state == S_FIN) & (~r_out_valid | i_out_ready);

    // Clamp the sample off the rails, then pick numerator and denominator.
    always_comb begin
        if (i_adc_sample == '0) begin
            w_sample = ADC_BITS'(1);
        end else if (i_adc_sample == ADC_FULL) begin
            w_sample = ADC_TOP;
        end else begin
            w_sample = i_adc_sample;
        end
        if (r_hwb) begin
            w_num = w_sample;
            w_den = ADC_FULL - w_sample;
        end else begin
            w_num = ADC_FULL - w_sample;
            w_den = w_sample;
        end
        w_fix_eff = (r_fix == '0) ? RES_W'(1) : r_fix;
    end

    // Shift-add steps: add the multiplicand when the multiplier LSB is set,
    // then shift the accumulator pair right by one.
    always_comb begin
        w_pa_sum = {1'b0, r_pa_hi} + (r_num[0] ? {1'b0, r_rref} : '0);
        w_pb_sum = {1'b0, r_pb_hi} + (r_den[0] ? {1'b0, w_fix_eff} : '0);
        w_a_sum  = {1'b0, r_a_hi} + (r_a_y[0] ? {1'b0, r_ratio} : '0);
        w_m2_sum = {1'b0, r_m2_hi} + (r_m2_y[0] ? {1'b0, r_a_hi, r_a_lo} : '0);
    end

    // Round half up at bit RND_SH and saturate to the output width.
    always_comb begin
        w_prod  = {r_m2_hi, r_m2_lo};
        w_round = {1'b0, w_prod[RND_SH+LUX_W-1:RND_SH]} + (LUX_W+1)'(w_prod[RND_SH-1]);
        w_sat   = (|w_prod[P_W-1:RND_SH+LUX_W]) | w_round[LUX_W];
        w_lux   = w_sat ? '1 : w_round[LUX_W-1:0];
    end

    lal_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend ({r_pa_hi, r_pa_lo, FRAC_W'(0)}),
        .i_divisor  ({r_pb_hi, r_pb_lo}),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    lal_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_radicand (SQ_W'(r_ratio)),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // Sequencer and configuration next-state logic
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_fix        = r_fix;
        n_rref       = r_rref;
        n_rlux       = r_rlux;
        n_hwb        = r_hwb;
        n_div_start  = 1'b0;
        n_sqrt_start = 1'b0;
        n_a_run      = r_a_run;
        n_out_valid  = r_out_valid & ~i_out_ready;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIXED_RES:   n_fix  = i_cfg_data[RES_W-1:0];
                CFG_REF_RES:     n_rref = i_cfg_data[RES_W-1:0];
                CFG_REF_LUX:     n_rlux = i_cfg_data[LUX_REF_W-1:0];
                CFG_HIGH_BRIGHT: n_hwb  = i_cfg_data[0];
                default:         n_hwb  = r_hwb;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_MUL1;
                    n_cnt   = '0;
                end
            end
            S_MUL1: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(ADC_BITS - 1)) begin
                    n_state     = S_DIV;
                    n_div_start = 1'b1;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state      = S_SQRT;
                    n_sqrt_start = 1'b1;
                    n_a_run      = 1'b1;
                    n_cnt        = '0;
                end
            end
            S_SQRT: begin
                // Form reference_lux * ratio while the root is worked out.
                if (r_a_run) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == STEP_CNT_W'(LUX_REF_W - 1)) begin
                        n_a_run = 1'b0;
                    end
                end
                if (w_sqrt_done) begin
                    n_state = S_MUL2;
                    n_cnt   = '0;
                end
            end
            S_MUL2: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(ROOT_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Hold until the output register is free, then drop back to idle.
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_fix        <= FIXED_RES_RST;
            r_rref       <= REF_RES_RST;
            r_rlux       <= REF_LUX_RST;
            r_hwb        <= 1'b0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_a_run      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_fix        <= n_fix;
            r_rref       <= n_rref;
            r_rlux       <= n_rlux;
            r_hwb        <= n_hwb;
            r_div_start  <= n_div_start;
            r_sqrt_start <= n_sqrt_start;
            r_a_run      <= n_a_run;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath: shift registers and accumulators, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_num   <= w_num;
            r_den   <= w_den;
            r_pa_hi <= '0;
            r_pb_hi <= '0;
        end else if (r_state == S_MUL1) begin
            r_num   <= r_num >> 1;
            r_den   <= r_den >> 1;
            r_pa_hi <= w_pa_sum[RES_W:1];
            r_pa_lo <= {w_pa_sum[0], r_pa_lo[ADC_BITS-1:1]};
            r_pb_hi <= w_pb_sum[RES_W:1];
            r_pb_lo <= {w_pb_sum[0], r_pb_lo[ADC_BITS-1:1]};
        end

        if ((r_state == S_DIV) && w_div_done) begin
            r_ratio <= w_quo;
            r_a_y   <= r_rlux;
            r_a_hi  <= '0;
        end else if ((r_state == S_SQRT) && r_a_run) begin
            r_a_y   <= r_a_y >> 1;
            r_a_hi  <= w_a_sum[NUM_W:1];
            r_a_lo  <= {w_a_sum[0], r_a_lo[LUX_REF_W-1:1]};
        end

        if ((r_state == S_SQRT) && w_sqrt_done) begin
            r_m2_y  <= w_root;
            r_m2_hi <= '0;
        end else if (r_state == S_MUL2) begin
            r_m2_y  <= r_m2_y >> 1;
            r_m2_hi <= w_m2_sum[A_W:1];
            r_m2_lo <= {w_m2_sum[0], r_m2_lo[ROOT_W-1:1]};
        end

        if (w_out_load) begin
            r_lux <= w_lux;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lux       = r_lux;

    // Sequencing checks
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_root_after_lux_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (!r_a_run && (r_state == S_SQRT)))
        else $error("square root finished before reference product was ready");

    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_MUL1))
        else $error("accepted sample did not start the product phase");

    a_fin_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !r_out_valid) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("finished result not moved into the output register");

endmodule
`default_nettype wire

// ===== bench/photoresistor_adc_to_lux_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// photoresistor_adc_to_lux_unit_tb: self-checking bench for the LDR lux unit
// Drives ADC samples and register writes over valid/ready channels. A
// scoreboard predicts every lux value from its own copy of the registers, and
// each result is compared in order. The random part runs under three idling
// profiles and a fresh register setting per batch.
// ----------------------------------------------------------------------------
module photoresistor_adc_to_lux_unit_tb;
    import lal_pkg::*;

    // Tolerated run of cycles with no transfer on any channel.
    localparam int STALL_LIMIT  = 4000;
    // Cycles to watch for stray results once nothing is outstanding.
    localparam int SETTLE_TAIL  = 150;
    localparam int BATCH_ITEMS  = 50;
    localparam int BATCH_COUNT  = 13;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [ADC_BITS-1:0] sample;
        logic [LUX_W-1:0]    lux;
    } t_lux_expect;

    // ------------------------------------------------------------------------
    // Scoreboard: register shadow, lux predictor and in-order result check
    // ------------------------------------------------------------------------
    class t_lux_scoreboard;
        logic [RES_W-1:0]     fixed_ohms;
        logic [RES_W-1:0]     ref_ohms;
        logic [LUX_REF_W-1:0] ref_lux;
        logic                 bright_high;
        t_lux_expect          lux_pending_q[$];
        int unsigned          error_count;

        function new();
            fixed_ohms  = FIXED_RES_RST;
            ref_ohms    = REF_RES_RST;
            ref_lux     = REF_LUX_RST;
            bright_high = 1'b0;
            error_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FIXED_RES:   fixed_ohms  = data[RES_W-1:0];
                CFG_REF_RES:     ref_ohms    = data[RES_W-1:0];
                CFG_REF_LUX:     ref_lux     = data[LUX_REF_W-1:0];
                CFG_HIGH_BRIGHT: bright_high = data[0];
                default: ;
            endcase
        endfunction

        // Bit-pair integer square root, one result bit per step.
        function logic [63:0] root_of(logic [63:0] v);
            logic [63:0] pair_bit;
            logic [63:0] acc;
            logic [63:0] rem;
            rem      = v;
            acc      = '0;
            pair_bit = 64'd1 << 62;
            while (pair_bit > rem)
                pair_bit = pair_bit >> 2;
            while (pair_bit != 0) begin
                if (rem >= acc + pair_bit) begin
                    rem = rem - (acc + pair_bit);
                    acc = (acc >> 1) + pair_bit;
                end else begin
                    acc = acc >> 1;
                end
                pair_bit = pair_bit >> 2;
            end
            return acc;
        endfunction

        function logic [LUX_W-1:0] predict_lux(logic [ADC_BITS-1:0] sample);
            logic [ADC_BITS-1:0] s;
            logic [ADC_BITS-1:0] num;
            logic [ADC_BITS-1:0] den;
            logic [63:0]         rfix;
            logic [63:0]         ratio;
            logic [63:0]         root;
            logic [127:0]        product;
            // Keep the sample off both rails.
            s = sample;
            if (s == '0)
                s = ADC_BITS'(1);
            else if (s >= ADC_FULL)
                s = ADC_TOP;
            if (bright_high) begin
                num = s;
                den = ADC_FULL - s;
            end else begin
                num = ADC_FULL - s;
                den = s;
            end
            rfix    = (fixed_ohms == '0) ? 64'd1 : 64'(fixed_ohms);
            ratio   = ((64'(ref_ohms) * 64'(num)) << FRAC_W) / (rfix * 64'(den));
            root    = root_of(ratio);
            product = 128'(ref_lux) * 128'(ratio) * 128'(root) + (128'd1 << (RND_SH - 1));
            product = product >> RND_SH;
            return (product > 128'hFFFF_FFFF) ? '1 : product[LUX_W-1:0];
        endfunction

        function void note_sample(logic [ADC_BITS-1:0] sample);
            t_lux_expect e;
            e.sample = sample;
            e.lux    = predict_lux(sample);
            lux_pending_q.push_back(e);
        endfunction

        function void check_lux(logic [LUX_W-1:0] actual);
            t_lux_expect e;
            if (lux_pending_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected lux result %0d", actual);
                return;
            end
            e = lux_pending_q.pop_front();
            if (actual !== e.lux) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("lux mismatch: sample %0d expected %0d got %0d",
                             e.sample, e.lux, actual);
            end
        endfunction

        function int pending();
            return lux_pending_q.size();
        endfunction

        function bit failed();
            return (error_count != 0) || (lux_pending_q.size() != 0);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, all inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic [ADC_BITS-1:0]   i_adc_sample = '0;
    logic                  i_out_ready  = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [LUX_W-1:0]      o_lux;
    logic                  o_cfg_ready;

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned stall_cycles      = 0;

    t_lux_scoreboard lux_board;

    photoresistor_adc_to_lux_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_adc_sample (i_adc_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_lux        (o_lux),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Result side: toggle ready at random and check every transfer. Values
    // read here are the ones settled before the edge.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready)
            lux_board.check_lux(o_lux);
    end

    // Watchdog: any transfer restarts the count; a long silence ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one sample and hold it until the transfer. Valid stays high on
    // return so back-to-back samples need no drop; an idle gap drops it first.
    task automatic send_sample(input logic [ADC_BITS-1:0] sample);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_adc_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        lux_board.note_sample(sample);
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (lux_board.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        lux_board.set_register(idx, data);
    endtask

    // Write all four registers back to back; only call with the unit idle.
    task automatic program_config(input logic [CFG_DATA_W-1:0] fixed_word,
                                  input logic [CFG_DATA_W-1:0] ref_word,
                                  input logic [CFG_DATA_W-1:0] lux_word,
                                  input logic [CFG_DATA_W-1:0] polarity_word);
        write_register(CFG_FIXED_RES, fixed_word);
        write_register(CFG_REF_RES, ref_word);
        write_register(CFG_REF_LUX, lux_word);
        write_register(CFG_HIGH_BRIGHT, polarity_word);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_batch(input logic [ADC_BITS-1:0] samples[$]);
        foreach (samples[k])
            send_sample(samples[k]);
        drain_results();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_resistance();
        case ($urandom_range(9))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'd0;
            3, 4, 5: return 16'($urandom_range(2000, 40000));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_lux_word();
        case ($urandom_range(7))
            0:       return 16'd1;
            1:       return 16'd1000;
            2:       return 16'($urandom());  // upper bits must be dropped
            default: return 16'($urandom_range(1, 1000));
        endcase
    endfunction

    // Mostly uniform, with extra weight on and near both rails.
    function automatic logic [ADC_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return ($urandom_range(1)) ? ADC_FULL : '0;
            1:       return ADC_BITS'($urandom_range(0, 15));
            2:       return ADC_FULL - ADC_BITS'($urandom_range(0, 15));
            default: return ADC_BITS'($urandom_range(0, (1 << ADC_BITS) - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        lux_board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the busy-receiver profile.
        sender_idle_pct   = 26;
        receiver_idle_pct = 73;

        // Reset registers: rails, mid-scale and alternating bit patterns.
        run_batch('{12'd0, 12'd1, 12'd2, 12'd2047, 12'd2048, 12'd4093, 12'd4094,
                    12'd4095, 12'hAAA, 12'h555});

        // Largest ratio with the sample on top: drive into saturation.
        program_config(16'd1, 16'hFFFF, 16'd1000, 16'd1);
        run_batch('{12'd0, 12'd4094, 12'd4095, 12'd2048, 12'd1});

        // Smallest ratio: results round toward zero.
        program_config(16'hFFFF, 16'd1, 16'd1, 16'd0);
        run_batch('{12'd4094, 12'd4095, 12'd2048});

        // Zero fixed resistance counts as one ohm; polarity word with bit 0 low.
        program_config(16'd0, 16'd10000, 16'd10, 16'hFFFE);
        run_batch('{12'd100, 12'd3000});

        // Zero reference resistance forces a zero result.
        program_config(16'd10000, 16'd0, 16'd10, 16'd1);
        run_batch('{12'd2000});

        // Zero reference lux, reached through masked upper data bits.
        program_config(16'd10000, 16'd10000, 16'hFC00, 16'd1);
        run_batch('{12'd2000});

        // Random batches, each under a fresh register setting. Advance the
        // idling profile: busy receiver, then busy sender, then none.
        for (int b = 0; b < BATCH_COUNT; b++) begin
            if (b < 5) begin
                sender_idle_pct   = 26;
                receiver_idle_pct = 73;
            end else if (b < 9) begin
                sender_idle_pct   = 73;
                receiver_idle_pct = 26;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            program_config(pick_resistance(), pick_resistance(), pick_lux_word(),
                           16'($urandom()));
            for (int k = 0; k < BATCH_ITEMS; k++)
                send_sample(pick_sample());
            drain_results();
        end

        // Watch for stray results, then report.
        repeat (SETTLE_TAIL) @(posedge i_clk);
        if (lux_board.failed())
            $display("[FAIL] regression broken");
        else
            $display("[ OK ] regression clean");
        $finish;
    end

endmodule
